FILE: rtl/core/lpmr_pkg.sv
// Package for the length-prefixed message ring.
// Holds the shared codes, widths, state and config types.
// No dependencies.
package lpmr_pkg;

  localparam int BufferBytes = 4096;
  localparam int AddrW       = $clog2(BufferBytes);
  localparam int OffW        = AddrW + 1;
  localparam int MaxMessage  = 64;
  localparam int HdrBytes    = 4;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_PEEK   = 3'd2;
  localparam logic [2:0] OP_DROP   = 3'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BADLEN  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_WRAP    = 3'd4;
  localparam logic [2:0] ST_CORRUPT = 3'd5;
  localparam logic [2:0] ST_SMALL   = 3'd6;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ACTIVE  = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  localparam logic [0:0] REG_QUEUE_LEN   = 1'b0;
  localparam logic [0:0] REG_RESERVE_LEN = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_WR,
    S_HDR,
    S_CHK,
    S_STRM
  } lpmr_state_t;

  typedef struct packed {
    logic [OffW-1:0] queue_len;
    logic [11:0]     reserve_len;
    logic            clear;
  } lpmr_cfg_t;

  function automatic logic [AddrW-1:0] ring_addr(logic [OffW-1:0] p, logic [OffW-1:0] ql);
    logic [OffW-1:0] d;
    d = (p >= ql) ? p - ql : p;
    return d[AddrW-1:0];
  endfunction

endpackage

FILE: rtl/core/lpmr_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module lpmr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/lpmr_ctrl.sv
// Sequencer for the message ring: offsets, push phase, header fetch, streaming.
// Depends on lpmr_pkg; drives the ring RAM port.
module lpmr_ctrl
  import lpmr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lpmr_cfg_t        cfg,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_operation,
  input  logic [7:0]       in_data_byte,
  input  logic [6:0]       in_message_length,
  input  logic             in_last_byte,
  input  logic [6:0]       in_max_out_length,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [7:0]       out_data_byte_res,
  output logic [6:0]       out_message_length_res,
  output logic             out_last,
  output logic [12:0]      out_used_length,
  output logic [12:0]      out_free_length,
  output logic             ram_we,
  output logic [AddrW-1:0] ram_addr,
  output logic [7:0]       ram_wdata,
  input  logic [7:0]       ram_rdata
);

  lpmr_state_t state_r, state_nxt;
  logic [OffW-1:0] head_r, head_nxt, tail_r, tail_nxt, wm_r, wm_nxt;
  logic            wmv_r, wmv_nxt;
  logic            wrapd_r, wrapd_nxt;
  logic [OffW-1:0] wp_r, wp_nxt, base_r, base_nxt, p_r, p_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [6:0]      pend_r, pend_nxt, recv_r, recv_nxt;
  logic [2:0]      disc_r, disc_nxt, st_r, st_nxt;
  logic [2:0]      wcnt_r, wcnt_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [6:0]      maxo_r, maxo_nxt, len_r, len_nxt, i_r, i_nxt;
  logic            jump_r, jump_nxt;
  logic [31:0]     hdr_r, hdr_nxt;
  logic            ov_r, ov_nxt, olast_r, olast_nxt, osel_r, osel_nxt;
  logic [2:0]      ost_r, ost_nxt;
  logic [6:0]      olen_r, olen_nxt;

  logic [14:0]     used_x;
  logic            used_bad;
  logic [OffW-1:0] span, free_v;
  logic [OffW-1:0] need, start_pos, wpn, hnew, hsum;
  logic            wrap;
  logic [2:0]      pf_st;
  logic            hdr_bad;
  logic [6:0]      vlen;

  always_comb begin
    if (head_r == tail_r) begin
      used_x = '0;
    end else if (head_r < tail_r) begin
      used_x = {2'b0, tail_r - head_r};
    end else if (wmv_r) begin
      used_x = {2'b0, wm_r} + {2'b0, tail_r} - {2'b0, head_r};
    end else begin
      used_x = {2'b0, cfg.queue_len} - {2'b0, head_r} + {2'b0, tail_r};
    end
    used_bad = used_x[14] || (used_x > {2'b0, cfg.queue_len}) || (used_x <= 15'(HdrBytes));
    if (head_r == tail_r) begin
      span = cfg.queue_len;
    end else if (head_r < tail_r) begin
      span = cfg.queue_len - (tail_r - head_r);
    end else begin
      span = head_r - tail_r;
    end
    free_v = (span < {1'b0, cfg.reserve_len}) ? '0 : span - {1'b0, cfg.reserve_len};
  end

  always_comb begin
    need  = OffW'(in_message_length) + OffW'(HdrBytes);
    wrap  = 1'b0;
    pf_st = ST_OK;
    if (in_message_length == '0 || in_message_length > 7'(MaxMessage)) begin
      pf_st = ST_BADLEN;
    end else if (free_v < need || span <= need) begin
      pf_st = ST_FULL;
    end else if ((cfg.queue_len - tail_r) < need) begin
      if (wmv_r) begin
        pf_st = ST_WRAP;
      end else if (head_r > tail_r) begin
        pf_st = ST_CORRUPT;
      end else if (head_r <= need) begin
        pf_st = ST_FULL;
      end else begin
        wrap = 1'b1;
      end
    end
    start_pos = wrap ? '0 : tail_r;
  end

  always_comb begin
    vlen    = hdr_r[6:0];
    hdr_bad = (hdr_r[31:7] != '0) || (vlen == '0) || (vlen > 7'(MaxMessage)) ||
              ({8'b0, vlen} > used_x - 15'(HdrBytes));
    hsum    = p_r + OffW'(HdrBytes) + OffW'(vlen);
    hnew    = (hsum >= cfg.queue_len) ? hsum - cfg.queue_len : hsum;
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r; tail_nxt = tail_r; wm_nxt = wm_r; wmv_nxt = wmv_r;
    wrapd_nxt = wrapd_r;
    wp_nxt = wp_r; base_nxt = base_r; p_nxt = p_r;
    phase_nxt = phase_r; pend_nxt = pend_r; recv_nxt = recv_r;
    disc_nxt = disc_r; st_nxt = st_r; wcnt_nxt = wcnt_r; byte_nxt = byte_r;
    op_nxt = op_r; maxo_nxt = maxo_r; len_nxt = len_r; i_nxt = i_r;
    jump_nxt = jump_r; hdr_nxt = hdr_r;
    ov_nxt = 1'b0; olast_nxt = 1'b1; osel_nxt = 1'b0; ost_nxt = ost_r; olen_nxt = olen_r;
    ram_we = 1'b0; ram_wdata = '0;
    ram_addr = ring_addr(p_r, cfg.queue_len);
    wpn = wp_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_operation;
          maxo_nxt = in_max_out_length;
          case (in_operation)
            OP_PUSH: begin
              byte_nxt = in_data_byte;
              if (phase_r == PH_DISCARD) begin
                ov_nxt = 1'b1; ost_nxt = disc_r; olen_nxt = '0;
                if (in_last_byte) begin
                  phase_nxt = PH_IDLE;
                end
              end else if (phase_r == PH_IDLE && pf_st != ST_OK) begin
                ov_nxt = 1'b1; ost_nxt = pf_st; olen_nxt = '0;
                disc_nxt  = pf_st;
                phase_nxt = in_last_byte ? PH_IDLE : PH_DISCARD;
              end else begin
                if (phase_r == PH_IDLE) begin
                  base_nxt  = start_pos;
                  wcnt_nxt  = '0;
                  wpn       = start_pos + OffW'(HdrBytes + 1);
                  pend_nxt  = in_message_length;
                  recv_nxt  = 7'd1;
                  wrapd_nxt = wrap;
                end else begin
                  base_nxt = wp_r - OffW'(HdrBytes);
                  wcnt_nxt = 3'(HdrBytes);
                  wpn      = wp_r + 1'b1;
                  recv_nxt = recv_r + 1'b1;
                end
                wp_nxt    = wpn;
                phase_nxt = PH_ACTIVE;
                st_nxt    = ST_OK;
                if (recv_nxt >= pend_nxt) begin
                  if ((phase_r == PH_IDLE) ? wrap : wrapd_r) begin
                    wm_nxt  = tail_r;
                    wmv_nxt = 1'b1;
                  end
                  wrapd_nxt = 1'b0;
                  tail_nxt = (wpn >= cfg.queue_len) ? wpn - cfg.queue_len : wpn;
                  if (in_last_byte) begin
                    phase_nxt = PH_IDLE;
                  end else begin
                    phase_nxt = PH_DISCARD;
                    disc_nxt  = ST_BADLEN;
                  end
                end else if (in_last_byte) begin
                  phase_nxt = PH_IDLE;
                  st_nxt    = ST_BADLEN;
                  wrapd_nxt = 1'b0;
                end
                state_nxt = S_PUSH_WR;
              end
            end
            OP_POP, OP_PEEK, OP_DROP: begin
              if (used_x == '0) begin
                ov_nxt = 1'b1; ost_nxt = ST_EMPTY; olen_nxt = '0;
              end else if (used_bad) begin
                ov_nxt = 1'b1; ost_nxt = ST_CORRUPT; olen_nxt = '0;
              end else begin
                jump_nxt  = wmv_r && (head_r == wm_r);
                p_nxt     = jump_nxt ? '0 : head_r;
                wcnt_nxt  = '0;
                state_nxt = S_HDR;
              end
            end
            default: begin
              ov_nxt = 1'b1; ost_nxt = ST_OK; olen_nxt = '0;
            end
          endcase
        end
      end
      S_PUSH_WR: begin
        ram_we    = 1'b1;
        ram_addr  = ring_addr(base_r + OffW'(wcnt_r), cfg.queue_len);
        ram_wdata = (wcnt_r == 3'd0) ? {1'b0, pend_r} :
                    (wcnt_r == 3'(HdrBytes)) ? byte_r : 8'd0;
        wcnt_nxt  = wcnt_r + 1'b1;
        if (wcnt_r == 3'(HdrBytes)) begin
          ov_nxt = 1'b1; ost_nxt = st_r; olen_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_HDR: begin
        ram_addr = ring_addr(p_r + OffW'(wcnt_r), cfg.queue_len);
        if (wcnt_r != 3'd0) begin
          hdr_nxt = {ram_rdata, hdr_r[31:8]};
        end
        wcnt_nxt = wcnt_r + 1'b1;
        if (wcnt_r == 3'(HdrBytes)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        len_nxt   = vlen;
        i_nxt     = '0;
        state_nxt = S_IDLE;
        if (hdr_bad) begin
          ov_nxt = 1'b1; ost_nxt = ST_CORRUPT; olen_nxt = '0;
        end else if (op_r == OP_POP && vlen > maxo_r) begin
          ov_nxt = 1'b1; ost_nxt = ST_SMALL; olen_nxt = vlen;
        end else begin
          if (op_r != OP_PEEK) begin
            head_nxt = hnew;
            if (jump_r) begin
              wmv_nxt = 1'b0;
            end
          end
          if (op_r == OP_DROP) begin
            ov_nxt = 1'b1; ost_nxt = ST_OK; olen_nxt = vlen;
          end else begin
            state_nxt = S_STRM;
          end
        end
      end
      S_STRM: begin
        ram_addr  = ring_addr(p_r + OffW'(HdrBytes) + OffW'(i_r), cfg.queue_len);
        ov_nxt    = 1'b1;
        osel_nxt  = 1'b1;
        ost_nxt   = ST_OK;
        olen_nxt  = len_r;
        olast_nxt = (i_r + 1'b1 == len_r);
        i_nxt     = i_r + 1'b1;
        if (olast_nxt) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg.clear) begin
      head_nxt = '0; tail_nxt = '0; wm_nxt = '0; wmv_nxt = 1'b0; wp_nxt = '0;
      phase_nxt = PH_IDLE; pend_nxt = '0; recv_nxt = '0; disc_nxt = ST_OK;
      wrapd_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; wm_r <= '0; wmv_r <= 1'b0; wp_r <= '0;
      phase_r <= PH_IDLE; pend_r <= '0; recv_r <= '0; disc_r <= ST_OK;
      wrapd_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; wm_r <= wm_nxt; wmv_r <= wmv_nxt;
      wp_r <= wp_nxt; phase_r <= phase_nxt; pend_r <= pend_nxt; recv_r <= recv_nxt;
      disc_r <= disc_nxt;
      wrapd_r <= wrapd_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt; p_r <= p_nxt; st_r <= st_nxt; wcnt_r <= wcnt_nxt;
    byte_r <= byte_nxt; op_r <= op_nxt; maxo_r <= maxo_nxt; len_r <= len_nxt;
    i_r <= i_nxt; jump_r <= jump_nxt; hdr_r <= hdr_nxt;
    olast_r <= olast_nxt; osel_r <= osel_nxt; ost_r <= ost_nxt; olen_r <= olen_nxt;
  end

  assign busy                   = (state_r != S_IDLE);
  assign out_valid              = ov_r;
  assign out_status             = ost_r;
  assign out_data_byte_res      = osel_r ? ram_rdata : 8'd0;
  assign out_message_length_res = olen_r;
  assign out_last               = olast_r;
  assign out_used_length        = used_x[12:0];
  assign out_free_length        = free_v;

endmodule

FILE: rtl/core/length_prefixed_message_ring.sv
// Top level of the length-prefixed message ring: APB registers, ring RAM, sequencer.
// Depends on lpmr_pkg, lpmr_ram and lpmr_ctrl.
//
// An item is taken when start is high and busy is low; one item runs at a time.
// A stored push byte is written through the single RAM port; the first byte of a
// message first writes the 4-byte length header through that port; a refused or
// swallowed push byte answers straight from idle. Pop and peek fetch the header, then
// stream one byte per cycle; drop and pops that fail on the stored header answer after
// the header fetch and check; an empty queue or a bad used count answers straight
// from idle, as does status. Each result is a one-cycle strobe on out_valid that cannot
// be held off; out_last marks the final result of an item.
module length_prefixed_message_ring
  import lpmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic [6:0]  in_message_length,
  input  logic        in_last_byte,
  input  logic [6:0]  in_max_out_length,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_data_byte_res,
  output logic [6:0]  out_message_length_res,
  output logic        out_last,
  output logic [12:0] out_used_length,
  output logic [12:0] out_free_length
);

  logic [OffW-1:0] ql_r, ql_nxt;
  logic [11:0]     res_r, res_nxt;
  logic            clr_nxt;
  logic            wr_en;
  lpmr_cfg_t       cfg;
  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]      ram_wdata, ram_rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    ql_nxt  = ql_r;
    res_nxt = res_r;
    clr_nxt = 1'b0;
    if (wr_en) begin
      case (paddr[2])
        REG_QUEUE_LEN: begin
          if (pwdata[12:0] < 13'd8) begin
            ql_nxt = OffW'(8);
          end else if (pwdata[12:0] > 13'(BufferBytes)) begin
            ql_nxt = OffW'(BufferBytes);
          end else begin
            ql_nxt = OffW'(pwdata[12:0]);
          end
          clr_nxt = 1'b1;
        end
        REG_RESERVE_LEN: res_nxt = pwdata[11:0];
        default: res_nxt = res_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ql_r  <= OffW'(BufferBytes);
      res_r <= '0;
    end else begin
      ql_r  <= ql_nxt;
      res_r <= res_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_RESERVE_LEN) ? {20'b0, res_r} : 32'(ql_r);

  assign cfg.queue_len   = ql_r;
  assign cfg.reserve_len = res_r;
  assign cfg.clear       = clr_nxt;

  lpmr_ram #(.Width(8), .Depth(BufferBytes)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lpmr_ctrl u_ctrl (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg),
    .start                  (start),
    .busy                   (busy),
    .in_operation           (in_operation),
    .in_data_byte           (in_data_byte),
    .in_message_length      (in_message_length),
    .in_last_byte           (in_last_byte),
    .in_max_out_length      (in_max_out_length),
    .out_valid              (out_valid),
    .out_status             (out_status),
    .out_data_byte_res      (out_data_byte_res),
    .out_message_length_res (out_message_length_res),
    .out_last               (out_last),
    .out_used_length        (out_used_length),
    .out_free_length        (out_free_length),
    .ram_we                 (ram_we),
    .ram_addr               (ram_addr),
    .ram_wdata              (ram_wdata),
    .ram_rdata              (ram_rdata)
  );

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item made no progress");

  a_stream_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("message stream broke off");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_last)
    else $error("error result not final");

endmodule

FILE: bench/tb_length_prefixed_message_ring.sv
// Testbench for length_prefixed_message_ring: drives command items and APB register
// writes, predicts every result with a behavioral copy of the ring, checks each strobe.
// Depends on lpmr_pkg and the length_prefixed_message_ring RTL.
module tb_length_prefixed_message_ring;
  import lpmr_pkg::*;

  localparam logic [2:0] OP_STATUS = 3'd4;
  localparam int CycleLimit = 1000000;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  data;
    logic [6:0]  len;
    logic        last;
    logic [12:0] used;
    logic [12:0] free;
  } ring_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [2:0]  in_operation;
  logic [7:0]  in_data_byte;
  logic [6:0]  in_message_length;
  logic        in_last_byte;
  logic [6:0]  in_max_out_length;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_data_byte_res;
  logic [6:0]  out_message_length_res;
  logic        out_last;
  logic [12:0] out_used_length;
  logic [12:0] out_free_length;

  length_prefixed_message_ring i_dut (.*);

  ring_result_t pending_results[$];
  int           err_count;
  int           cycle_count;
  int           burst_left;
  bit           gaps_on;

  // Behavioral ring state
  logic [7:0]  ring_mem [0:BufferBytes-1];
  int unsigned q_len, rsv_len, head, tail, wmark, wpos, pend_len, recv_cnt;
  logic [2:0]  discard_st;
  bit          wmark_valid, wrap_due;
  logic [1:0]  phase;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned span_free();
    if (head == tail) return q_len;
    if (head < tail) return q_len - (tail - head);
    return head - tail;
  endfunction

  function automatic int unsigned free_len();
    int unsigned s;
    s = span_free();
    return (s < rsv_len) ? 0 : s - rsv_len;
  endfunction

  function automatic int unsigned used_len();
    if (head == tail) return 0;
    if (head < tail) return tail - head;
    if (wmark_valid) return wmark - head + tail;
    return q_len - head + tail;
  endfunction

  function automatic logic [7:0] ring_rd(int unsigned p);
    return ring_mem[p % q_len];
  endfunction

  function automatic void ring_wr(int unsigned p, logic [7:0] v);
    ring_mem[p % q_len] = v;
  endfunction

  function automatic void clear_ring();
    head = 0; tail = 0; wmark = 0; wmark_valid = 0; wpos = 0;
    phase = PH_IDLE; pend_len = 0; recv_cnt = 0; wrap_due = 0; discard_st = ST_OK;
  endfunction

  function automatic logic [2:0] find_head(output int unsigned pos, output int unsigned len,
                                           output bit jump);
    int unsigned used, p, v;
    used = used_len();
    p = head;
    jump = 0; len = 0; pos = 0;
    if (used == 0) return ST_EMPTY;
    if (used > q_len || used <= HdrBytes) return ST_CORRUPT;
    if (wmark_valid && head == wmark) begin
      p = 0;
      jump = 1;
    end
    v = ring_rd(p) | (ring_rd(p + 1) << 8) | (ring_rd(p + 2) << 16) | (ring_rd(p + 3) << 24);
    if (v == 0 || v > MaxMessage || v > used - HdrBytes) return ST_CORRUPT;
    pos = p;
    len = v;
    return ST_OK;
  endfunction

  function automatic void advance_head(int unsigned pos, int unsigned len, bit jump);
    int unsigned h;
    h = pos + HdrBytes + len;
    if (jump) wmark_valid = 0;
    if (h >= q_len) h -= q_len;
    head = h;
  endfunction

  function automatic logic [2:0] open_record(int unsigned len, logic [7:0] b);
    int unsigned need, base;
    bit wrap;
    need = len + HdrBytes;
    wrap = 0;
    if (len == 0 || len > MaxMessage) return ST_BADLEN;
    if (free_len() < need || span_free() <= need) return ST_FULL;
    if (q_len - tail < need) begin
      if (wmark_valid) return ST_WRAP;
      if (head > tail) return ST_CORRUPT;
      if (head <= need) return ST_FULL;
      wrap = 1;
    end
    base = wrap ? 0 : tail;
    for (int i = 0; i < HdrBytes; i++) ring_wr(base + i, 8'(len >> (8 * i)));
    ring_wr(base + HdrBytes, b);
    wpos = base + HdrBytes + 1;
    pend_len = len;
    recv_cnt = 1;
    wrap_due = wrap;
    phase = PH_ACTIVE;
    return ST_OK;
  endfunction

  function automatic logic [2:0] push_one(logic [7:0] b, logic [6:0] mlen, logic lastb);
    logic [2:0] st;
    if (phase == PH_DISCARD) begin
      st = discard_st;
      if (lastb) phase = PH_IDLE;
      return st;
    end
    if (phase == PH_IDLE) begin
      st = open_record(mlen, b);
      if (st != ST_OK) begin
        discard_st = st;
        phase = lastb ? PH_IDLE : PH_DISCARD;
        return st;
      end
    end else begin
      ring_wr(wpos, b);
      wpos++;
      recv_cnt++;
    end
    if (recv_cnt >= pend_len) begin
      if (wrap_due) begin
        wmark = tail;
        wmark_valid = 1;
      end
      tail = (wpos >= q_len) ? wpos - q_len : wpos;
      wrap_due = 0;
      if (lastb) phase = PH_IDLE;
      else begin
        phase = PH_DISCARD;
        discard_st = ST_BADLEN;
      end
      return ST_OK;
    end
    if (lastb) begin
      phase = PH_IDLE;
      wrap_due = 0;
      return ST_BADLEN;
    end
    return ST_OK;
  endfunction

  function automatic void predict_item(logic [2:0] op, logic [7:0] b, logic [6:0] mlen,
                                       logic lastb, logic [6:0] maxo);
    ring_result_t r[$];
    ring_result_t one;
    int unsigned pos, len;
    bit jump;
    logic [2:0] st;
    one = '{default: '0};
    one.last = 1'b1;
    if (op == OP_PUSH) begin
      one.status = push_one(b, mlen, lastb);
      r.push_back(one);
    end else if (op == OP_POP || op == OP_PEEK) begin
      st = find_head(pos, len, jump);
      if (st == ST_OK && op == OP_POP && len > maxo) st = ST_SMALL;
      if (st != ST_OK) begin
        one.status = st;
        one.len = (st == ST_SMALL) ? 7'(len) : 7'd0;
        r.push_back(one);
      end else begin
        for (int unsigned i = 0; i < len; i++) begin
          one.data = ring_rd(pos + HdrBytes + i);
          one.len = 7'(len);
          one.last = (i + 1 == len);
          r.push_back(one);
        end
        if (op == OP_POP) advance_head(pos, len, jump);
      end
    end else if (op == OP_DROP) begin
      st = find_head(pos, len, jump);
      if (st == ST_OK) advance_head(pos, len, jump);
      one.status = st;
      one.len = (st == ST_OK) ? 7'(len) : 7'd0;
      r.push_back(one);
    end else begin
      r.push_back(one);
    end
    foreach (r[k]) begin
      r[k].used = 13'(used_len());
      r[k].free = 13'(free_len());
      pending_results.push_back(r[k]);
    end
  endfunction

  always @(posedge clk) begin
    ring_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d data %0h", out_status, out_data_byte_res);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          err_count++;
        end
        if (out_data_byte_res !== e.data) begin
          $error("data_byte_res: expected %0h, actual %0h", e.data, out_data_byte_res);
          err_count++;
        end
        if (out_message_length_res !== e.len) begin
          $error("message_length_res: expected %0d, actual %0d", e.len,
                 out_message_length_res);
          err_count++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_last);
          err_count++;
        end
        if (out_used_length !== e.used) begin
          $error("used_length: expected %0d, actual %0d", e.used, out_used_length);
          err_count++;
        end
        if (out_free_length !== e.free) begin
          $error("free_length: expected %0d, actual %0d", e.free, out_free_length);
          err_count++;
        end
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [7:0] b, logic [6:0] mlen, logic lastb,
                           logic [6:0] maxo);
    bit taken;
    taken = 0;
    start = 1'b1;
    in_operation = op;
    in_data_byte = b;
    in_message_length = mlen;
    in_last_byte = lastb;
    in_max_out_length = maxo;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1;
        predict_item(op, b, mlen, lastb, maxo);
      end
    end
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
    start = 1'b0;
  endtask

  task automatic push_message(int n, int claimed, bit random_len_field);
    for (int i = 0; i < n; i++)
      send_item(OP_PUSH, 8'($urandom_range(0, 255)),
                (i == 0 || !random_len_field) ? claimed[6:0] : 7'($urandom_range(0, 127)),
                i == n - 1, 7'($urandom_range(0, 64)));
  endtask

  task automatic drain();
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_QUEUE_LEN) begin
      q_len = value[12:0];
      if (q_len < 8) q_len = 8;
      if (q_len > BufferBytes) q_len = BufferBytes;
      clear_ring();
    end else begin
      rsv_len = value[11:0];
    end
  endtask

  task automatic test_directed();
    send_item(OP_STATUS, 8'h00, 7'd0, 1'b0, 7'd0);
    send_item(OP_POP, 8'h00, 7'd0, 1'b0, 7'd64);
    send_item(OP_PEEK, 8'h00, 7'd0, 1'b0, 7'd64);
    send_item(OP_DROP, 8'h00, 7'd0, 1'b0, 7'd0);
    send_item(OP_PUSH, 8'hFF, 7'd0, 1'b1, 7'd0);
    push_message(3, 65, 0);
    push_message(1, 1, 0);
    push_message(2, 3, 0);
    push_message(4, 2, 0);
    send_item(OP_PEEK, 8'h00, 7'd0, 1'b0, 7'd0);
    send_item(OP_POP, 8'h00, 7'd0, 1'b0, 7'd0);
    send_item(OP_POP, 8'h00, 7'd0, 1'b0, 7'd64);
    send_item(OP_DROP, 8'h00, 7'd0, 1'b0, 7'd0);
    for (int i = 0; i < 64; i++)
      send_item(OP_PUSH, (i % 2) ? 8'hFF : 8'h00, 7'd64, i == 63, 7'd127);
    send_item(3'd5, 8'h00, 7'd0, 1'b0, 7'd0);
    send_item(3'd6, 8'h00, 7'd0, 1'b0, 7'd0);
    send_item(3'd7, 8'hFF, 7'd127, 1'b1, 7'd127);
    send_item(OP_POP, 8'h00, 7'd0, 1'b0, 7'd63);
    send_item(OP_POP, 8'h00, 7'd0, 1'b0, 7'd64);
  endtask

  task automatic random_traffic(int items);
    int k, sel, n, ln;
    k = 0;
    while (k < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        ln = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        n = ln;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, ln + 2);
        if ($urandom_range(0, 19) == 0) ln = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
        push_message(n, ln, 1);
        k += n;
      end else begin
        if (sel < 65) send_item(OP_POP, 8'($urandom), 7'($urandom), 1'($urandom),
                                7'($urandom_range(0, 64)));
        else if (sel < 78) send_item(OP_PEEK, 8'($urandom), 7'($urandom), 1'($urandom),
                                     7'($urandom));
        else if (sel < 90) send_item(OP_DROP, 8'($urandom), 7'($urandom), 1'($urandom),
                                     7'($urandom));
        else send_item(3'($urandom_range(4, 7)), 8'($urandom), 7'($urandom), 1'($urandom),
                       7'($urandom));
        k++;
      end
    end
  endtask

  task automatic test_default_ring();
    gaps_on = 1;
    random_traffic(40);
  endtask

  task automatic test_wrap_small();
    write_reg(REG_QUEUE_LEN, 32'd0);
    push_message(1, 1, 0);
    push_message(1, 1, 0);
    send_item(OP_POP, 8'h00, 7'd0, 1'b0, 7'd64);
    write_reg(REG_QUEUE_LEN, 32'd60);
    write_reg(REG_RESERVE_LEN, 32'd6);
    random_traffic(60);
    write_reg(REG_QUEUE_LEN, 32'd100);
    write_reg(REG_RESERVE_LEN, 32'd0);
    gaps_on = 0;
    random_traffic(30);
  endtask

  task automatic test_reserve_extremes();
    gaps_on = 1;
    write_reg(REG_QUEUE_LEN, 32'h1FFF);
    write_reg(REG_RESERVE_LEN, 32'd4095);
    push_message(2, 2, 0);
    send_item(OP_STATUS, 8'h00, 7'd0, 1'b0, 7'd0);
    write_reg(REG_RESERVE_LEN, 32'hFFFF_F000);
    write_reg(REG_QUEUE_LEN, 32'd4096);
    random_traffic(25);
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    burst_left = 0;
    gaps_on = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0;
    in_operation = OP_STATUS; in_data_byte = '0; in_message_length = '0;
    in_last_byte = 1'b0; in_max_out_length = '0;
    q_len = BufferBytes;
    rsv_len = 0;
    clear_ring();
    for (int i = 0; i < BufferBytes; i++) ring_mem[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_default_ring();
    test_wrap_small();
    test_reserve_extremes();
    drain();
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lpmr_pkg.sv
rtl/core/lpmr_ram.sv
rtl/core/lpmr_ctrl.sv
rtl/core/length_prefixed_message_ring.sv
bench/tb_length_prefixed_message_ring.sv
